FILE: rtl/range_edge_gap_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Range edge gap classifier: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_EDGE_GAP_CLASSIFIER_CORE_MACROS_SVH
`define RANGE_EDGE_GAP_CLASSIFIER_CORE_MACROS_SVH

// checked only outside reset
`define RGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RGC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rgc_pkg.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: package
// Widths, register map, reset values and shared types.
// ----------------------------------------------------------------------------
package rgc_pkg;

	localparam int RANGE_W     = 16;
	localparam int INDEX_W     = 12;
	localparam int KIND_W      = 2;
	localparam int SCAN_POINTS = 512;

	// register map
	localparam int REG_INDEX_W = 3;
	localparam logic [REG_INDEX_W-1:0] REG_FREE_LEVEL = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_NEAR_LIMIT = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_SMALL_STEP = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_BIG_STEP   = 3'd3;

	localparam logic [RANGE_W-1:0] FREE_LEVEL_RST = 16'd2810;
	localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 16'd2720;
	localparam logic [RANGE_W-1:0] SMALL_STEP_RST = 16'd50;
	localparam logic [RANGE_W-1:0] BIG_STEP_RST   = 16'd200;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [KIND_W-1:0] {
		GAP_LEFT    = 2'd0,
		GAP_CENTRAL = 2'd1,
		GAP_RIGHT   = 2'd2
	} gap_kind_t;

	typedef struct packed {
		logic [RANGE_W-1:0] free_level;
		logic [RANGE_W-1:0] near_limit;
		logic [RANGE_W-1:0] small_step;
		logic [RANGE_W-1:0] big_step;
	} cfg_t;

	typedef struct packed {
		gap_kind_t          kind;
		logic [INDEX_W-1:0] left_index;
		logic [RANGE_W-1:0] left_range;
		logic [INDEX_W-1:0] right_index;
		logic [RANGE_W-1:0] right_range;
		logic               last_of_run;
	} result_t;

	// results produced by one sample: count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

FILE: rtl/rgc_in_if.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: sample channel
// Valid/ready channel carrying one range sample per word.
// ----------------------------------------------------------------------------
interface rgc_in_if;
	logic                        valid;
	logic                        ready;
	logic [rgc_pkg::RANGE_W-1:0] range_mm;
	logic                        scan_start;

	modport source (output valid, output range_mm, output scan_start, input ready);
	modport sink   (input valid, input range_mm, input scan_start, output ready);
endinterface

FILE: rtl/rgc_out_if.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: gap channel
// Valid/ready channel carrying one gap report per word.
// ----------------------------------------------------------------------------
interface rgc_out_if;
	logic                        valid;
	logic                        ready;
	logic [rgc_pkg::KIND_W-1:0]  gap_kind;
	logic [rgc_pkg::INDEX_W-1:0] left_index;
	logic [rgc_pkg::RANGE_W-1:0] left_range_mm;
	logic [rgc_pkg::INDEX_W-1:0] right_index;
	logic [rgc_pkg::RANGE_W-1:0] right_range_mm;
	logic                        last_of_run;

	modport source (output valid, output gap_kind, output left_index, output left_range_mm,
		output right_index, output right_range_mm, output last_of_run, input ready);
	modport sink   (input valid, input gap_kind, input left_index, input left_range_mm,
		input right_index, input right_range_mm, input last_of_run, output ready);
endinterface

FILE: rtl/rgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: configuration registers
// Four 16-bit thresholds written through a plain write port.
// ----------------------------------------------------------------------------
module rgc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rgc_pkg::REG_INDEX_W-1:0] cfg_wr_index,
	input  logic [rgc_pkg::RANGE_W-1:0]     cfg_wr_data,
	output rgc_pkg::cfg_t                   cfg
);

	rgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.free_level <= rgc_pkg::FREE_LEVEL_RST;
			cfg_q.near_limit <= rgc_pkg::NEAR_LIMIT_RST;
			cfg_q.small_step <= rgc_pkg::SMALL_STEP_RST;
			cfg_q.big_step   <= rgc_pkg::BIG_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_wr_index)
				rgc_pkg::REG_FREE_LEVEL: cfg_q.free_level <= cfg_wr_data;
				rgc_pkg::REG_NEAR_LIMIT: cfg_q.near_limit <= cfg_wr_data;
				rgc_pkg::REG_SMALL_STEP: cfg_q.small_step <= cfg_wr_data;
				rgc_pkg::REG_BIG_STEP:   cfg_q.big_step   <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/rgc_classifier.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: edge classification
// Input register, scan state and the edge rules for one sample.
// ----------------------------------------------------------------------------
module rgc_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rgc_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rgc_pkg::RANGE_W-1:0] in_range_mm,
	input  logic                        in_scan_start,
	input  logic                        space_ok,
	output rgc_pkg::push_t              push
);

	localparam int IW = rgc_pkg::INDEX_W;
	localparam int RW = rgc_pkg::RANGE_W;
	localparam logic [IW:0] IDX_LIMIT = (IW+1)'(rgc_pkg::SCAN_POINTS);

	logic          valid_s1;
	logic [RW-1:0] range_s1;
	logic          start_s1;

	logic [RW-1:0] prev_range_q;
	logic [IW-1:0] beam_index_q;
	logic          run_open_q;
	logic [IW-1:0] run_start_index_q;
	logic [RW-1:0] run_start_range_q;

	logic          adv;
	logic [IW-1:0] idx_raw, idx, idx_prev, beam_next;
	logic [IW:0]   idx_inc;
	logic signed [RW+1:0] diff, small_s, big_s;
	logic          first_beam;
	logic          rise_small, rise_big, fall_small, fall_big;
	logic          open_run, emit_left, emit_central, emit_right;
	rgc_pkg::result_t res_first, res_right;

	assign adv      = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			range_s1 <= in_range_mm;
			start_s1 <= in_scan_start;
		end
	end

	always_comb begin
		idx_raw    = start_s1 ? '0 : beam_index_q;
		idx        = ({1'b0, idx_raw} >= IDX_LIMIT) ? '0 : idx_raw;
		first_beam = (idx == '0);
		idx_prev   = idx - IW'(1);
		idx_inc    = {1'b0, idx} + (IW+1)'(1);
		beam_next  = (idx_inc >= IDX_LIMIT) ? '0 : idx_inc[IW-1:0];

		diff    = $signed({2'b00, range_s1}) - $signed({2'b00, prev_range_q});
		small_s = $signed({2'b00, cfg.small_step});
		big_s   = $signed({2'b00, cfg.big_step});

		rise_small = diff > small_s;
		rise_big   = diff > big_s;
		fall_small = diff < -small_s;
		fall_big   = -diff > big_s;

		// a left gap is only taken from a rise that already counts as an edge
		open_run     = !first_beam && rise_small && (range_s1 > cfg.free_level);
		emit_left    = !first_beam && rise_small && rise_big;
		emit_central = !first_beam && fall_small && run_open_q
			&& (prev_range_q > cfg.free_level);
		emit_right   = !first_beam && fall_big && (prev_range_q < cfg.near_limit)
			&& (idx > IW'(1));
	end

	// left and central gaps never coincide, a right gap only pairs with a central one
	always_comb begin
		res_first.kind        = emit_central ? rgc_pkg::GAP_CENTRAL :
			(emit_left ? rgc_pkg::GAP_LEFT : rgc_pkg::GAP_RIGHT);
		res_first.left_index  = emit_central ? run_start_index_q : idx_prev;
		res_first.left_range  = emit_central ? run_start_range_q : prev_range_q;
		res_first.right_index = idx;
		res_first.right_range = range_s1;
		res_first.last_of_run = !(emit_central && emit_right);

		res_right.kind        = rgc_pkg::GAP_RIGHT;
		res_right.left_index  = idx_prev;
		res_right.left_range  = prev_range_q;
		res_right.right_index = idx;
		res_right.right_range = range_s1;
		res_right.last_of_run = 1'b1;

		push.r0    = res_first;
		push.r1    = res_right;
		push.count = adv ? (2'({1'b0, emit_left}) + 2'({1'b0, emit_central})
			+ 2'({1'b0, emit_right})) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_range_q      <= '0;
			beam_index_q      <= '0;
			run_open_q        <= 1'b0;
			run_start_index_q <= '0;
			run_start_range_q <= '0;
		end else if (adv) begin
			prev_range_q <= range_s1;
			beam_index_q <= beam_next;
			if (first_beam || emit_central) begin
				run_open_q <= 1'b0;
			end else if (open_run) begin
				run_open_q        <= 1'b1;
				run_start_index_q <= idx_prev;
				run_start_range_q <= prev_range_q;
			end
		end
	end

endmodule

FILE: rtl/rgc_result_queue.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: result queue
// Four-word queue, up to two words written and one read per cycle.
// ----------------------------------------------------------------------------
module rgc_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  rgc_pkg::push_t   push,
	output logic             space_ok,
	output logic             out_valid,
	input  logic             out_ready,
	output rgc_pkg::result_t out_word
);

	localparam int PW = rgc_pkg::QPTR_W;
	localparam int CW = rgc_pkg::QCNT_W;

	rgc_pkg::result_t fifo_q [rgc_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	// room for two words whatever the reader does this cycle
	assign space_ok  = count_q <= CW'(rgc_pkg::QUEUE_DEPTH - 2);
	assign out_valid = (count_q != '0);
	assign out_word  = fifo_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			fifo_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			fifo_q[wr_ptr_q + PW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

FILE: rtl/range_edge_gap_classifier_core.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier core
// Classifies a stream of laser range samples into left, central and right gaps.
// ----------------------------------------------------------------------------
// Usage:
//  samples : one beam range (mm) per word, scan_start marks beam 0 of a scan.
//  gaps    : zero, one or two gap reports per sample, last_of_run set on the
//            final report of each sample; a central gap precedes a right gap.
//  cfg     : write-only thresholds, written while the block is idle;
//            indices above three are ignored.
// Path: a sample's first report passes through the input register, then the
//  four-word result queue, before it is offered on the gap channel.
// Throughput: one sample per cycle while the gap receiver keeps up; the queue
//  drains one report per cycle, so samples yielding two reports slow intake.
// Stall: a stalled receiver holds the queue head; intake stops once the queue
//  cannot take two more words, and nothing is dropped.
// Reset: thresholds return to their defaults, beam index, previous range and
//  the open run clear, the queue empties.
// ----------------------------------------------------------------------------
module range_edge_gap_classifier_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rgc_pkg::REG_INDEX_W-1:0] cfg_wr_index,
	input  logic [rgc_pkg::RANGE_W-1:0]     cfg_wr_data,
	rgc_in_if.sink                          samples,
	rgc_out_if.source                       gaps
);

	rgc_pkg::cfg_t    cfg;
	rgc_pkg::push_t   push;
	rgc_pkg::result_t head;
	logic             space_ok;

	rgc_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_index (cfg_wr_index),
		.cfg_wr_data  (cfg_wr_data),
		.cfg          (cfg)
	);

	rgc_classifier u_cls (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (samples.valid),
		.in_ready      (samples.ready),
		.in_range_mm   (samples.range_mm),
		.in_scan_start (samples.scan_start),
		.space_ok      (space_ok),
		.push          (push)
	);

	rgc_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (gaps.valid),
		.out_ready (gaps.ready),
		.out_word  (head)
	);

	assign gaps.gap_kind       = head.kind;
	assign gaps.left_index     = head.left_index;
	assign gaps.left_range_mm  = head.left_range;
	assign gaps.right_index    = head.right_index;
	assign gaps.right_range_mm = head.right_range;
	assign gaps.last_of_run    = head.last_of_run;

endmodule

FILE: rtl/rgc_checker.sv
// ----------------------------------------------------------------------------
// Range edge gap classifier: port checker
// Watches the gap channel of the core and is bound to it.
// ----------------------------------------------------------------------------
`include "range_edge_gap_classifier_core_macros.svh"

module rgc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rgc_pkg::KIND_W-1:0]  gap_kind,
	input logic [rgc_pkg::INDEX_W-1:0] left_index,
	input logic [rgc_pkg::RANGE_W-1:0] left_range_mm,
	input logic [rgc_pkg::INDEX_W-1:0] right_index,
	input logic [rgc_pkg::RANGE_W-1:0] right_range_mm
);

	logic adjacent_kind;

	assign adjacent_kind = (gap_kind == rgc_pkg::GAP_LEFT) || (gap_kind == rgc_pkg::GAP_RIGHT);

	`RGC_ASSERT_ALWAYS(a_no_word_in_reset, !arst_n |-> !out_valid, "gap word offered in reset")
	`RGC_ASSERT(a_word_held, out_valid && !out_ready |=> out_valid, "stalled gap word dropped")
	`RGC_ASSERT(a_kind_legal, out_valid |-> (gap_kind == rgc_pkg::GAP_LEFT) || (gap_kind == rgc_pkg::GAP_CENTRAL) || (gap_kind == rgc_pkg::GAP_RIGHT), "undefined gap kind")
	`RGC_ASSERT(a_adjacent_ends, out_valid && adjacent_kind |-> right_index == left_index + 12'd1, "left/right gap ends not adjacent beams")
	`RGC_ASSERT(a_left_rises, out_valid && gap_kind == rgc_pkg::GAP_LEFT |-> right_range_mm > left_range_mm, "left gap without a rise")

endmodule

bind range_edge_gap_classifier_core rgc_checker u_rgc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (gaps.valid),
	.out_ready      (gaps.ready),
	.gap_kind       (gaps.gap_kind),
	.left_index     (gaps.left_index),
	.left_range_mm  (gaps.left_range_mm),
	.right_index    (gaps.right_index),
	.right_range_mm (gaps.right_range_mm)
);
